>>> src/button_debounce_tap_hold_unit_macros.svh
// Assertion macros shared by the button debounce / tap-hold RTL.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef BUTTON_DEBOUNCE_TAP_HOLD_UNIT_MACROS_SVH
`define BUTTON_DEBOUNCE_TAP_HOLD_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define BDTH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define BDTH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BDTH_ASSERT_IMP(lbl, ante, cons, msg)
`define BDTH_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> src/bdth_pkg.sv
// Shared types and constants for the button debounce / tap-hold unit.
// No dependencies; used by bdth_core, bdth_evq and the top level.
package bdth_pkg;

  localparam int NUM_BUTTONS_DEF = 5;
  localparam int MAX_BUTTONS     = 5;
  localparam int BTN_W           = 3;
  localparam int TIME_W          = 32;
  localparam int DEB_W           = 10;
  localparam int FLAGS_W         = 15;
  localparam int HOLD_W          = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;

  localparam logic [DEB_W-1:0]  DEBOUNCE_RST = 10'd50;
  localparam logic [HOLD_W-1:0] HOLD_RST     = 16'd1000;

  // Per-button binding flag positions inside one 3-bit group
  localparam int FLAG_HOLD    = 0;
  localparam int FLAG_INSTANT = 1;
  localparam int FLAG_REBIND  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 3'd0,
    CFG_BINDING  = 3'd1,
    CFG_HOLD_0   = 3'd2,
    CFG_HOLD_1   = 3'd3,
    CFG_HOLD_2   = 3'd4,
    CFG_HOLD_3   = 3'd5,
    CFG_HOLD_4   = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_HOLD    = 2'd2,
    KIND_INSTANT = 2'd3
  } kind_t;

  // Events caused by one sample, k0 first
  typedef struct packed {
    logic [BTN_W-1:0] button;
    logic [1:0]       cnt;
    kind_t            k0;
    kind_t            k1;
    kind_t            k2;
  } evt_t;

  typedef logic [MAX_BUTTONS-1:0][HOLD_W-1:0] hold_arr_t;

endpackage

>>> src/button_debounce_tap_hold_unit.sv
// Button debounce with tap, hold and instant-action events.
// Usage:
//   in_*  : one poll sample per request: tdata = button[2:0], level[3]
//           (0 = pressed), now_ms[35:4], upper bits zero.
//   out_* : one event per request: tdata[2:0] = button, tuser = kind
//           (press, release, hold action, instant action), tlast marks the
//           final event of a sample. A sample may give zero to three events.
//   cfg_* : register writes (debounce, binding flags, five hold thresholds),
//           taken at any edge with cfg_wr_en high; write only while idle.
// Path: a sample is taken into the input register; once the result register is
// free, the events of the sample are loaded there and the first is offered.
// Throughput: one sample per cycle while each gives at most one event and
// out_tready is high; a sample with more events holds the result register until
// its last leaves; the output moves one event a cycle while out_tready is high.
// Reset: buttons read as released with cleared timers and flags, registers take
// their default values, both channels go empty.
// Output stall: events wait in the result register; the input register fills,
// then in_tready drops until the stall clears. Nothing is dropped.
// Depends on bdth_pkg, bdth_core and bdth_evq.
module button_debounce_tap_hold_unit #(
  parameter int NUM_BUTTONS = bdth_pkg::NUM_BUTTONS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [39:0]                       in_tdata,   // button[2:0], level[3], now_ms[35:4]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata,  // event_button[2:0]
  output logic [1:0]                        out_tuser,  // event_kind[1:0]
  output logic                              out_tlast,
  input  logic                              cfg_wr_en,
  input  logic [bdth_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bdth_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);

  logic [bdth_pkg::DEB_W-1:0]     debounce_r;
  logic [bdth_pkg::FLAGS_W-1:0]   flags_r;
  bdth_pkg::hold_arr_t            hold_r;
  logic [bdth_pkg::CFG_IDX_W-1:0] hold_idx;

  logic                           s1_valid_r;
  logic [bdth_pkg::BTN_W-1:0]     s1_button_r;
  logic                           s1_pressed_r;
  logic [bdth_pkg::TIME_W-1:0]    s1_now_r;

  logic                           free;
  logic                           go;
  logic                           in_acc;
  bdth_pkg::evt_t                 evt;
  logic [bdth_pkg::BTN_W-1:0]     out_button;
  bdth_pkg::kind_t                out_kind;

  // configuration registers
  assign hold_idx = cfg_index - bdth_pkg::CFG_HOLD_0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= bdth_pkg::DEBOUNCE_RST;
      flags_r    <= '0;
      for (int i = 0; i < bdth_pkg::MAX_BUTTONS; i++) begin
        hold_r[i] <= bdth_pkg::HOLD_RST;
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_index) inside
        bdth_pkg::CFG_DEBOUNCE: debounce_r <= cfg_wr_data[bdth_pkg::DEB_W-1:0];
        bdth_pkg::CFG_BINDING:  flags_r    <= cfg_wr_data[bdth_pkg::FLAGS_W-1:0];
        bdth_pkg::CFG_HOLD_0, bdth_pkg::CFG_HOLD_1, bdth_pkg::CFG_HOLD_2,
        bdth_pkg::CFG_HOLD_3, bdth_pkg::CFG_HOLD_4: begin
          hold_r[hold_idx] <= cfg_wr_data;
        end
        default: ;
      endcase
    end
  end

  // input register
  assign go        = s1_valid_r && free;
  assign in_tready = !s1_valid_r || free;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_button_r  <= in_tdata[2:0];
      s1_pressed_r <= !in_tdata[3];
      s1_now_r     <= in_tdata[35:4];
    end
  end

  bdth_core #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .go            (go),
    .button        (s1_button_r),
    .pressed       (s1_pressed_r),
    .now           (s1_now_r),
    .debounce_ms   (debounce_r),
    .binding_flags (flags_r),
    .hold_ms       (hold_r),
    .evt           (evt)
  );

  bdth_evq u_evq (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (go),
    .evt        (evt),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_button (out_button),
    .out_kind   (out_kind),
    .out_last   (out_tlast)
  );

  assign out_tdata = {5'b0, out_button};
  assign out_tuser = out_kind;

endmodule

>>> src/bdth_core.sv
// Per-button debounce state and the event decision for one sample.
// Depends on bdth_pkg and button_debounce_tap_hold_unit_macros.svh.
`include "button_debounce_tap_hold_unit_macros.svh"

module bdth_core #(
  parameter int NUM_BUTTONS = bdth_pkg::NUM_BUTTONS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           go,
  input  logic [bdth_pkg::BTN_W-1:0]     button,
  input  logic                           pressed,
  input  logic [bdth_pkg::TIME_W-1:0]    now,
  input  logic [bdth_pkg::DEB_W-1:0]     debounce_ms,
  input  logic [bdth_pkg::FLAGS_W-1:0]   binding_flags,
  input  bdth_pkg::hold_arr_t            hold_ms,
  output bdth_pkg::evt_t                 evt
);

  localparam int BW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  logic [NUM_BUTTONS-1:0]          stable_r;
  logic [NUM_BUTTONS-1:0]          pend_r;
  logic [NUM_BUTTONS-1:0]          fired_r;
  logic [NUM_BUTTONS-1:0]          cons_r;
  logic [bdth_pkg::TIME_W-1:0]     last_r  [NUM_BUTTONS];
  logic [bdth_pkg::TIME_W-1:0]     start_r [NUM_BUTTONS];

  logic                            stable_nxt;
  logic                            pend_nxt;
  logic                            fired_nxt;
  logic                            cons_nxt;
  logic [bdth_pkg::TIME_W-1:0]     last_nxt;
  logic [bdth_pkg::TIME_W-1:0]     start_nxt;

  logic [BW-1:0]                   sel;
  logic                            in_range;
  logic                            upd;
  logic [2:0]                      flags;
  logic [bdth_pkg::HOLD_W-1:0]     hold_sel;
  logic [bdth_pkg::TIME_W-1:0]     since_chg;
  logic [bdth_pkg::TIME_W-1:0]     since_press;
  logic                            deb_ok;
  logic                            hold_due;

  assign sel      = button[BW-1:0];
  assign in_range = button < bdth_pkg::BTN_W'(NUM_BUTTONS);
  assign upd      = go && in_range;

  always_comb begin
    flags    = '0;
    hold_sel = '0;
    for (int i = 0; i < bdth_pkg::MAX_BUTTONS; i++) begin
      if (button == bdth_pkg::BTN_W'(i)) begin
        flags    = binding_flags[3*i +: 3];
        hold_sel = hold_ms[i];
      end
    end
  end

  assign since_chg   = now - last_r[sel];
  assign since_press = now - start_r[sel];
  assign deb_ok      = since_chg >= {{(bdth_pkg::TIME_W-bdth_pkg::DEB_W){1'b0}}, debounce_ms};
  assign hold_due    = since_press >= {{(bdth_pkg::TIME_W-bdth_pkg::HOLD_W){1'b0}}, hold_sel};

  always_comb begin
    stable_nxt = stable_r[sel];
    pend_nxt   = pend_r[sel];
    fired_nxt  = fired_r[sel];
    cons_nxt   = cons_r[sel];
    last_nxt   = last_r[sel];
    start_nxt  = start_r[sel];
    evt.button = button;
    evt.cnt    = 2'd0;
    evt.k0     = bdth_pkg::KIND_PRESS;
    evt.k1     = bdth_pkg::KIND_RELEASE;
    evt.k2     = bdth_pkg::KIND_INSTANT;
    if (in_range) begin
      if (pressed != stable_r[sel]) begin
        if (deb_ok) begin
          stable_nxt = pressed;
          last_nxt   = now;
          if (pressed) begin
            start_nxt = now;
            fired_nxt = 1'b0;
            cons_nxt  = 1'b0;
            if (flags[bdth_pkg::FLAG_HOLD]) begin
              // defer the tap until release or hold timeout
              pend_nxt = 1'b1;
            end else begin
              pend_nxt = 1'b0;
              if (flags[bdth_pkg::FLAG_INSTANT]) begin
                if (flags[bdth_pkg::FLAG_REBIND]) begin
                  evt.cnt = 2'd2;
                  evt.k1  = bdth_pkg::KIND_INSTANT;
                end else begin
                  evt.cnt  = 2'd1;
                  evt.k0   = bdth_pkg::KIND_INSTANT;
                  cons_nxt = 1'b1;
                end
              end else begin
                evt.cnt = 2'd1;
              end
            end
          end else if (pend_r[sel]) begin
            // release with a hold pending: replay the tap only if the hold never fired
            if (!fired_r[sel]) begin
              evt.cnt = flags[bdth_pkg::FLAG_INSTANT] ? 2'd3 : 2'd2;
            end
            pend_nxt = 1'b0;
          end else if (cons_r[sel]) begin
            cons_nxt = 1'b0;
          end else begin
            evt.cnt = 2'd1;
            evt.k0  = bdth_pkg::KIND_RELEASE;
          end
        end
      end else if (stable_r[sel] && pend_r[sel] && !fired_r[sel] && hold_due) begin
        fired_nxt = 1'b1;
        evt.cnt   = 2'd1;
        evt.k0    = bdth_pkg::KIND_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= '0;
      pend_r   <= '0;
      fired_r  <= '0;
      cons_r   <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        last_r[i]  <= '0;
        start_r[i] <= '0;
      end
    end else if (upd) begin
      stable_r[sel] <= stable_nxt;
      pend_r[sel]   <= pend_nxt;
      fired_r[sel]  <= fired_nxt;
      cons_r[sel]   <= cons_nxt;
      last_r[sel]   <= last_nxt;
      start_r[sel]  <= start_nxt;
    end
  end

  `BDTH_ASSERT_IMP(a_pend_only_pressed, |pend_r, (pend_r & ~stable_r) == '0, "hold pending on a released button")
  `BDTH_ASSERT_IMP(a_cons_excl_pend, |cons_r, (cons_r & pend_r) == '0, "consumed press with hold pending")
  `BDTH_ASSERT_IMP(a_no_evt_out_of_range, go && !in_range, evt.cnt == 2'd0, "event for an unknown button")

endmodule

>>> src/bdth_evq.sv
// Result register: up to three events of a sample, one out per cycle while out_tready is high.
// Depends on bdth_pkg and button_debounce_tap_hold_unit_macros.svh.
`include "button_debounce_tap_hold_unit_macros.svh"

module bdth_evq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  bdth_pkg::evt_t             evt,
  output logic                       free,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [bdth_pkg::BTN_W-1:0] out_button,
  output bdth_pkg::kind_t            out_kind,
  output logic                       out_last
);

  logic [1:0]                 cnt_r;
  logic [bdth_pkg::BTN_W-1:0] btn_r;
  bdth_pkg::kind_t            k0_r;
  bdth_pkg::kind_t            k1_r;
  bdth_pkg::kind_t            k2_r;
  logic                       pop;

  assign out_tvalid = cnt_r != 2'd0;
  assign pop        = out_tvalid && out_tready;
  // take a new sample once the last pending event leaves
  assign free       = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_tready);
  assign out_button = btn_r;
  assign out_kind   = k0_r;
  assign out_last   = cnt_r == 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load) begin
      cnt_r <= evt.cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      btn_r <= evt.button;
      k0_r  <= evt.k0;
      k1_r  <= evt.k1;
      k2_r  <= evt.k2;
    end else if (pop) begin
      k0_r <= k1_r;
      k1_r <= k2_r;
    end
  end

  `BDTH_ASSERT_IMP(a_load_when_free, load, free, "sample loaded over pending events")
  `BDTH_ASSERT_NXT(a_pop_advances, pop && !load, cnt_r == $past(cnt_r) - 2'd1, "event count did not advance")
  `BDTH_ASSERT_NXT(a_hold_on_stall, out_tvalid && !out_tready && !load, cnt_r == $past(cnt_r), "events dropped while stalled")

endmodule

>>> tb/sv/bdth_event_checker.sv
// Event checker for button_debounce_tap_hold_unit: watches the sample, event and register
// ports, works out the events of every accepted sample and compares them in order.
// Depends on bdth_pkg only.
`timescale 1ns / 100ps
module bdth_event_checker
  import bdth_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [39:0]           in_tdata,     // button[2:0], level[3], now_ms[35:4]
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [7:0]            out_tdata,    // event_button[2:0]
  input  logic [1:0]            out_tuser,    // event_kind[1:0]
  input  logic                  out_tlast,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data,
  output int                    mismatch_count,
  output int                    owed_count
);

  localparam int NUM_BTN = NUM_BUTTONS_DEF;

  typedef struct packed {
    logic [BTN_W-1:0] button;
    kind_t            kind;
    logic             last;
  } btn_event_t;

  btn_event_t events_owed[$];

  // register copies
  logic [DEB_W-1:0]   debounce_window;
  logic [FLAGS_W-1:0] bind_bits;
  logic [HOLD_W-1:0]  hold_limit [NUM_BTN];

  // per-button state
  logic               settled_down  [NUM_BTN];
  logic [TIME_W-1:0]  change_stamp  [NUM_BTN];
  logic [TIME_W-1:0]  press_stamp   [NUM_BTN];
  logic               hold_armed    [NUM_BTN];
  logic               hold_done     [NUM_BTN];
  logic               tap_swallowed [NUM_BTN];

  function automatic logic bind_bit(input int b, input int which);
    return bind_bits[3 * b + which];
  endfunction

  task automatic predict_sample(input logic [BTN_W-1:0] b, input logic lv,
                                input logic [TIME_W-1:0] t);
    btn_event_t batch[$];
    logic down;
    down = ~lv;
    if (b >= NUM_BTN) return;
    if (down != settled_down[b]) begin
      // wrapping age against the debounce window
      if ((t - change_stamp[b]) >= debounce_window) begin
        settled_down[b] = down;
        change_stamp[b] = t;
        if (down) begin
          press_stamp[b]   = t;
          hold_done[b]     = 1'b0;
          tap_swallowed[b] = 1'b0;
          if (bind_bit(b, FLAG_HOLD)) begin
            hold_armed[b] = 1'b1;
          end else begin
            hold_armed[b] = 1'b0;
            if (bind_bit(b, FLAG_INSTANT)) begin
              if (bind_bit(b, FLAG_REBIND)) batch.push_back('{b, KIND_PRESS, 1'b0});
              batch.push_back('{b, KIND_INSTANT, 1'b0});
              tap_swallowed[b] = ~bind_bit(b, FLAG_REBIND);
            end else begin
              batch.push_back('{b, KIND_PRESS, 1'b0});
            end
          end
        end else if (hold_armed[b]) begin
          // deferred tap: replay it only if the hold never fired
          if (!hold_done[b]) begin
            batch.push_back('{b, KIND_PRESS, 1'b0});
            batch.push_back('{b, KIND_RELEASE, 1'b0});
            if (bind_bit(b, FLAG_INSTANT)) batch.push_back('{b, KIND_INSTANT, 1'b0});
          end
          hold_armed[b] = 1'b0;
        end else if (tap_swallowed[b]) begin
          tap_swallowed[b] = 1'b0;
        end else begin
          batch.push_back('{b, KIND_RELEASE, 1'b0});
        end
      end
    end else if (settled_down[b] && hold_armed[b] && !hold_done[b] &&
                 (t - press_stamp[b]) >= hold_limit[b]) begin
      hold_done[b] = 1'b1;
      batch.push_back('{b, KIND_HOLD, 1'b0});
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) events_owed.push_back(batch[i]);
  endtask

  always @(posedge clk) begin
    btn_event_t want;
    if (!rst_n) begin
      debounce_window = DEBOUNCE_RST;
      bind_bits       = '0;
      for (int i = 0; i < NUM_BTN; i++) begin
        hold_limit[i]    = HOLD_RST;
        settled_down[i]  = 1'b0;
        change_stamp[i]  = '0;
        press_stamp[i]   = '0;
        hold_armed[i]    = 1'b0;
        hold_done[i]     = 1'b0;
        tap_swallowed[i] = 1'b0;
      end
      events_owed.delete();
      mismatch_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (events_owed.size() == 0) begin
          $display("%0t: unexpected event: expected none, got button=%0d kind=%0d last=%0b",
                   $time, out_tdata[2:0], out_tuser, out_tlast);
          mismatch_count++;
        end else begin
          want = events_owed.pop_front();
          if (out_tdata[2:0] !== want.button || out_tuser !== want.kind ||
              out_tlast !== want.last) begin
            $display("%0t: event mismatch: expected button=%0d kind=%0d last=%0b, got button=%0d kind=%0d last=%0b",
                     $time, want.button, want.kind, want.last,
                     out_tdata[2:0], out_tuser, out_tlast);
            mismatch_count++;
          end
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_DEBOUNCE: debounce_window = cfg_wr_data[DEB_W-1:0];
          CFG_BINDING:  bind_bits = cfg_wr_data[FLAGS_W-1:0];
          CFG_HOLD_0, CFG_HOLD_1, CFG_HOLD_2, CFG_HOLD_3, CFG_HOLD_4: begin
            hold_limit[cfg_index - CFG_HOLD_0] = cfg_wr_data[HOLD_W-1:0];
          end
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_sample(in_tdata[2:0], in_tdata[3], in_tdata[35:4]);
    end
    owed_count = events_owed.size();
  end

endmodule

>>> tb/sv/tb_top.sv
// Top of the button debounce / tap-hold testbench: makes samples, register writes and
// ready/valid idling, and prints the verdict from the event checker's mismatch count.
// Depends on bdth_pkg, button_debounce_tap_hold_unit and bdth_event_checker.
`timescale 1ns / 100ps
module tb_top;
  import bdth_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int SAMPLES_PER_SETTING = 40;
  localparam int SETTLE_CYCLES       = 6;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [39:0]           in_tdata;     // button[2:0], level[3], now_ms[35:4]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;    // event_button[2:0]
  logic [1:0]            out_tuser;    // event_kind[1:0]
  logic                  out_tlast;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wr_data;
  int                    mismatch_count;
  int                    owed_count;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned deb_now = 50;
  int unsigned hold_now [NUM_BUTTONS_DEF];
  logic [31:0] clock_ms;
  int          samples_sent;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_idle_pct);

  button_debounce_tap_hold_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  bdth_event_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wr_data   (cfg_wr_data),
    .mismatch_count(mismatch_count),
    .owed_count    (owed_count)
  );

  // Keep in_tvalid high across back-to-back requests; callers lower it when done.
  task automatic send_sample(input logic [2:0] b, input logic lv, input logic [31:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, t, lv, b};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (b < NUM_BUTTONS_DEF) samples_sent++;
  endtask

  // Hold off until every owed event has come, then let samples with no events retire.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (owed_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= data;
    @(posedge clk);
  endtask

  // Unused upper data bits are filled with noise; the block must mask them.
  task automatic apply_setting(input int unsigned deb, input int unsigned flags,
                               input int unsigned hold_lo, input int unsigned hold_hi);
    deb_now = deb;
    write_reg(CFG_DEBOUNCE, {6'($urandom_range(63)), 10'(deb)});
    write_reg(CFG_BINDING, {1'($urandom_range(1)), 15'(flags)});
    for (int i = 0; i < NUM_BUTTONS_DEF; i++) begin
      hold_now[i] = $urandom_range(hold_hi, hold_lo);
      write_reg(cfg_idx_t'(CFG_HOLD_0 + i), 16'(hold_now[i]));
    end
    write_reg(CFG_UNUSED, 16'($urandom));
    cfg_wr_en <= 1'b0;
  endtask

  // Offset near a threshold: exactly on it, one either side, or anywhere up to twice it plus five.
  function automatic logic [31:0] around_ms(input int unsigned lim);
    case ($urandom_range(3))
      0:       return lim;
      1:       return lim - 1;
      2:       return lim + 1;
      default: return $urandom_range(2 * lim + 5);
    endcase
  endfunction

  initial begin
    logic [2:0]  b;
    logic [31:0] press_t;
    logic [31:0] rel_t;
    int          n_hold;
    bit          paused_once;
    paused_once = 1'b0;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_index   <= CFG_DEBOUNCE;
    cfg_wr_data <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset defaults first, so no release may come out of reset
    send_sample(3'd0, 1'b1, 32'd0);
    send_sample(3'd0, 1'b0, 32'd10);          // inside the debounce window
    send_sample(3'd0, 1'b0, 32'd60);          // press
    send_sample(3'd0, 1'b1, 32'd70);          // bounce, dropped
    send_sample(3'd0, 1'b1, 32'd110);         // release
    drain();
    // b0 none, b1 hold, b2 instant, b3 instant rebind, b4 hold + instant
    write_reg(CFG_BINDING, 16'h3C88);
    write_reg(CFG_HOLD_1, 16'd100);
    cfg_wr_en <= 1'b0;
    send_sample(3'd1, 1'b0, 32'd200);         // hold armed, nothing yet
    send_sample(3'd1, 1'b0, 32'd299);
    send_sample(3'd1, 1'b0, 32'd300);         // hold action
    send_sample(3'd1, 1'b0, 32'd400);
    send_sample(3'd1, 1'b1, 32'd500);         // release after hold: silent
    send_sample(3'd4, 1'b0, 32'd600);
    send_sample(3'd4, 1'b1, 32'd700);         // deferred tap: press, release, instant
    send_sample(3'd2, 1'b0, 32'd800);         // instant only
    send_sample(3'd2, 1'b1, 32'd900);         // consumed release
    send_sample(3'd3, 1'b0, 32'd1000);        // press, instant
    send_sample(3'd3, 1'b1, 32'd1100);        // release
    send_sample(3'd5, 1'b0, 32'd1200);        // out of range
    send_sample(3'd7, 1'b0, 32'hFFFF_FFFF);   // out of range
    send_sample(3'd0, 1'b0, 32'hFFFF_FFF0);   // press across the wrap
    send_sample(3'd0, 1'b1, 32'h0000_0020);   // 48 ms later: dropped
    send_sample(3'd0, 1'b1, 32'h0000_0022);   // exactly the window: release
    send_sample(3'd1, 1'b0, 32'hFFFF_FFFF);
    send_sample(3'd1, 1'b0, 32'h0000_0063);   // hold threshold reached across the wrap
    send_sample(3'd1, 1'b1, 32'h0000_0070);
    drain();

    clock_ms = 32'd5000;
    for (int s = 0; s < 6; s++) begin
      case (s / 2)
        0: begin
          send_idle_pct = 6;
          recv_idle_pct = 61;
        end
        1: begin
          send_idle_pct = 61;
          recv_idle_pct = 6;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (s)
        0:       apply_setting(0, 15'h7FFF, 0, 0);
        1:       apply_setting(1023, 0, 65535, 65535);
        default: apply_setting($urandom_range(120), $urandom_range(32767), 0, 2500);
      endcase
      if (s == 3) clock_ms = 32'hFFFE_0000 + $urandom_range(65535);
      samples_sent = 0;
      while (samples_sent < SAMPLES_PER_SETTING) begin
        if (s == 2 && !paused_once && samples_sent >= SAMPLES_PER_SETTING / 2) begin
          paused_once = 1'b1;
          drain();
        end
        if ($urandom_range(9) < 2) begin
          // noise: any button, any level, timestamp near or anywhere
          if ($urandom_range(1) == 1)
            send_sample(3'($urandom_range(7)), 1'($urandom_range(1)), $urandom);
          else
            send_sample(3'($urandom_range(7)), 1'($urandom_range(1)),
                        clock_ms + $urandom_range(deb_now + 20));
        end else begin
          // press / bounce / hold polls / release of one button
          b = 3'($urandom_range(NUM_BUTTONS_DEF - 1));
          clock_ms += deb_now + $urandom_range(30);
          press_t = clock_ms;
          n_hold  = $urandom_range(3);
          send_sample(b, 1'b0, press_t);
          if ($urandom_range(3) == 0) send_sample(b, 1'b1, press_t + $urandom_range(deb_now));
          for (int k = 0; k < n_hold; k++) send_sample(b, 1'b0, press_t + around_ms(hold_now[b]));
          rel_t = press_t + (($urandom_range(2) == 0) ? around_ms(deb_now)
                                                      : around_ms(hold_now[b]));
          send_sample(b, 1'b1, rel_t);
          if ($urandom_range(3) == 0) send_sample(b, 1'b0, rel_t + $urandom_range(deb_now));
          clock_ms = rel_t;
        end
      end
      drain();
    end

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
